/* rtl/i2cbb_pkg.sv */
// Shared types and constants for the I2C bit-level master sequencer.
`timescale 1ns / 1ps

package i2cbb_pkg;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd2;
    localparam int unsigned APB_ADDR_W = 3;
    // Register select bit of paddr (word address) for phase_ticks
    localparam logic REG_PHASE_TICKS = 1'b0;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE     = 4'd0,
        S_ST_A     = 4'd1,
        S_ST_B     = 4'd2,
        S_SP_A     = 4'd3,
        S_SP_B     = 4'd4,
        S_WR_DATA  = 4'd5,
        S_WR_HI    = 4'd6,
        S_WR_LO    = 4'd7,
        S_WR_AKHI  = 4'd8,
        S_WR_AKLO  = 4'd9,
        S_RD_HI    = 4'd10,
        S_RD_LO    = 4'd11,
        S_RD_AKSDA = 4'd12,
        S_RD_AKHI  = 4'd13,
        S_RD_AKLO  = 4'd14,
        S_RD_AKREL = 4'd15
    } t_state;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
        logic       cmd_rejected;
    } t_result;

endpackage

/* rtl/i2cbb_seq.sv */
// Bus phase sequencer: state registers and the per-tick next-state and result logic.
`timescale 1ns / 1ps

module i2cbb_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_tx_byte,
    input  logic              i_send_ack,
    input  logic              i_sda_in,
    input  logic [7:0]        i_phase_ticks,
    output i2cbb_pkg::t_result o_result
);
    import i2cbb_pkg::*;

    t_state     r_state,   n_state;
    logic [2:0] r_bit,     n_bit;
    logic [7:0] r_wait,    n_wait;
    logic [7:0] r_tx,      n_tx;
    logic [7:0] r_rx,      n_rx;
    logic       r_ack,     n_ack;
    logic       r_nack,    n_nack;
    logic       r_scl,     n_scl;
    logic       r_sda,     n_sda;
    logic [7:0] r_rx_last, n_rx_last;

    logic       enter_en;
    t_state     enter_st;
    logic [7:0] wait_load;
    logic [2:0] bit_pos;
    logic       is_last;
    logic       done;
    logic       rejected;

    assign wait_load = (i_phase_ticks == 8'd0) ? 8'd0 : i_phase_ticks - 8'd1;

    always_comb begin
        n_state   = r_state;
        n_bit     = r_bit;
        n_wait    = r_wait;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_ack     = r_ack;
        n_nack    = r_nack;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_rx_last = r_rx_last;
        enter_en  = 1'b0;
        enter_st  = S_IDLE;
        rejected  = 1'b0;
        done      = 1'b0;

        if (r_state == S_IDLE) begin
            n_bit = 3'd0;
            if (i_op == OP_START) begin
                enter_en = 1'b1;
                enter_st = S_ST_A;
            end else if (i_op == OP_STOP) begin
                enter_en = 1'b1;
                enter_st = S_SP_A;
            end else if (i_op == OP_WRITE) begin
                n_tx     = i_tx_byte;
                enter_en = 1'b1;
                enter_st = S_WR_DATA;
            end else if (i_op == OP_READ) begin
                n_rx     = 8'd0;
                n_ack    = i_send_ack;
                enter_en = 1'b1;
                enter_st = S_RD_HI;
            end
        end else begin
            rejected = (i_op != OP_TICK);
            if (r_wait != 8'd0) begin
                n_wait = r_wait - 8'd1;
            end else begin
                enter_en = 1'b1;
                unique case (r_state)
                    S_ST_A:     enter_st = S_ST_B;
                    S_SP_A:     enter_st = S_SP_B;
                    S_WR_DATA:  enter_st = S_WR_HI;
                    S_WR_HI:    enter_st = S_WR_LO;
                    S_WR_LO: begin
                        if (r_bit == 3'd7) begin
                            enter_st = S_WR_AKHI;
                        end else begin
                            n_bit    = r_bit + 3'd1;
                            enter_st = S_WR_DATA;
                        end
                    end
                    S_WR_AKHI:  enter_st = S_WR_AKLO;
                    S_RD_HI:    enter_st = S_RD_LO;
                    S_RD_LO: begin
                        if (r_bit == 3'd7) begin
                            enter_st = r_ack ? S_RD_AKSDA : S_RD_AKHI;
                        end else begin
                            n_bit    = r_bit + 3'd1;
                            enter_st = S_RD_HI;
                        end
                    end
                    S_RD_AKSDA: enter_st = S_RD_AKHI;
                    S_RD_AKHI:  enter_st = S_RD_AKLO;
                    S_RD_AKLO: begin
                        enter_en = r_ack;
                        enter_st = S_RD_AKREL;
                    end
                    default:    enter_en = 1'b0;
                endcase
            end
        end

        // MSB first: bit 0 of the count addresses bit 7 of the byte
        bit_pos = 3'd7 - n_bit;

        if (enter_en) begin
            n_state = enter_st;
            n_wait  = wait_load;
            unique case (enter_st)
                S_ST_A:     begin n_scl = 1'b0; n_sda = 1'b1; end
                S_ST_B:     begin n_scl = 1'b1; n_sda = 1'b1; end
                S_SP_A:     begin n_scl = 1'b0; n_sda = 1'b1; end
                S_SP_B:     n_sda = 1'b0;
                S_WR_DATA:  n_sda = ~n_tx[bit_pos];
                S_WR_HI:    n_scl = 1'b0;
                S_WR_LO:    n_scl = 1'b1;
                S_WR_AKHI:  begin n_sda = 1'b0; n_scl = 1'b0; end
                S_WR_AKLO:  begin n_nack = i_sda_in; n_scl = 1'b1; end
                S_RD_HI:    begin n_scl = 1'b0; n_sda = 1'b0; end
                S_RD_LO: begin
                    n_rx[bit_pos] = r_rx[bit_pos] | i_sda_in;
                    n_scl         = 1'b1;
                end
                S_RD_AKSDA: n_sda = 1'b1;
                S_RD_AKHI:  n_scl = 1'b0;
                S_RD_AKLO:  n_scl = 1'b1;
                S_RD_AKREL: n_sda = 1'b0;
                default:    n_state = enter_st;
            endcase
        end

        is_last = (n_state == S_ST_B) || (n_state == S_SP_B) || (n_state == S_WR_AKLO)
               || (n_state == S_RD_AKREL) || ((n_state == S_RD_AKLO) && !n_ack);

        if (n_state != S_IDLE && n_wait == 8'd0 && is_last) begin
            if (n_state == S_RD_AKLO || n_state == S_RD_AKREL) begin
                n_rx_last = n_rx;
            end
            n_state = S_IDLE;
            done    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit     <= 3'd0;
            r_wait    <= 8'd0;
            r_tx      <= 8'd0;
            r_rx      <= 8'd0;
            r_ack     <= 1'b0;
            r_nack    <= 1'b0;
            r_scl     <= 1'b0;
            r_sda     <= 1'b0;
            r_rx_last <= 8'd0;
        end else if (i_accept) begin
            r_state   <= n_state;
            r_bit     <= n_bit;
            r_wait    <= n_wait;
            r_tx      <= n_tx;
            r_rx      <= n_rx;
            r_ack     <= n_ack;
            r_nack    <= n_nack;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_rx_last <= n_rx_last;
        end
    end

    always_comb begin
        o_result.scl_low      = n_scl;
        o_result.sda_low      = n_sda;
        o_result.busy_res     = (n_state != S_IDLE);
        o_result.done_res     = done;
        o_result.rx_byte      = n_rx_last;
        o_result.ack_missing  = n_nack;
        o_result.cmd_rejected = rejected;
    end

endmodule

/* rtl/i2c_bitbang_master_core.sv */
// Top level of the I2C bit-level master: APB register, sequencer and output skid stage.
//
//  channel   direction  handshake          payload
//  tick in   in         i_valid / o_stall  i_op, i_tx_byte, i_send_ack, i_sda_in
//  result    out        o_valid / i_stall  o_scl_low, o_sda_low, o_busy_res, o_done_res,
//                                          o_rx_byte, o_ack_missing, o_cmd_rejected
//  config    in         APB psel/penable   paddr, pwdata, prdata (phase_ticks at 0x0)
//
// One tick word per clock while o_stall is low; its result word is registered in the output stage.
// The sequencer state and the result register sit on either side of one pass of logic.
// A two-entry output stage (register plus skid) lets one word in while a result stalls;
// o_stall rises only while the skid entry is occupied.
// Reset is synchronous: sequencer idle, pins released, phase_ticks back to 2.
`timescale 1ns / 1ps

module i2c_bitbang_master_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_op,
    input  logic [7:0]                        i_tx_byte,
    input  logic                              i_send_ack,
    input  logic                              i_sda_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_scl_low,
    output logic                              o_sda_low,
    output logic                              o_busy_res,
    output logic                              o_done_res,
    output logic [7:0]                        o_rx_byte,
    output logic                              o_ack_missing,
    output logic                              o_cmd_rejected,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cbb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import i2cbb_pkg::*;

    logic [7:0] r_phase_ticks;
    t_result    seq_result;
    t_result    r_out,  n_out;
    t_result    r_skid, n_skid;
    logic       r_out_valid,  n_out_valid;
    logic       r_skid_valid, n_skid_valid;
    logic       accept;
    logic       out_ready;
    logic       reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_PHASE_TICKS);
    assign prdata  = reg_hit ? {24'd0, r_phase_ticks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_phase_ticks <= pwdata[7:0];
        end
    end

    assign accept    = i_valid && !r_skid_valid;
    assign out_ready = !r_out_valid || !i_stall;
    assign o_stall   = r_skid_valid;

    i2cbb_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_op          (i_op),
        .i_tx_byte     (i_tx_byte),
        .i_send_ack    (i_send_ack),
        .i_sda_in      (i_sda_in),
        .i_phase_ticks (r_phase_ticks),
        .o_result      (seq_result)
    );

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_ready) begin
            // drain the skid entry first to keep word order
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = seq_result;
                n_out_valid = accept;
            end
        end else if (accept) begin
            n_skid       = seq_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid        = r_out_valid;
    assign o_scl_low      = r_out.scl_low;
    assign o_sda_low      = r_out.sda_low;
    assign o_busy_res     = r_out.busy_res;
    assign o_done_res     = r_out.done_res;
    assign o_rx_byte      = r_out.rx_byte;
    assign o_ack_missing  = r_out.ack_missing;
    assign o_cmd_rejected = r_out.cmd_rejected;

endmodule

/* rtl/i2cbb_chk.sv */
// Port-level checks for the I2C bit-level master, bound to the top level.
`timescale 1ns / 1ps

module i2cbb_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_scl_low,
    input logic                              o_sda_low,
    input logic                              o_busy_res,
    input logic                              o_done_res,
    input logic [7:0]                        o_rx_byte,
    input logic                              o_ack_missing,
    input logic                              o_cmd_rejected,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [i2cbb_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [31:0]                       pwdata,
    input logic [31:0]                       prdata,
    input logic                              pready
);
    import i2cbb_pkg::*;

    // Input side stalls only after a result word sat stalled on the output side
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> $past(o_valid && i_stall))
        else $error("input stalled without a stalled result word");

    // A completed command leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> !o_busy_res)
        else $error("done reported while still busy");

    // A phase_ticks write reads back on the next cycle
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1] == REG_PHASE_TICKS))
        |=> ((paddr[APB_ADDR_W-1] != REG_PHASE_TICKS) || (prdata[7:0] == $past(pwdata[7:0]))))
        else $error("phase_ticks read back differs from the written value");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rx_byte) && $stable(o_done_res)
                                  && $stable(o_scl_low) && $stable(o_sda_low)
                                  && $stable(o_busy_res) && $stable(o_ack_missing)
                                  && $stable(o_cmd_rejected)))
        else $error("stalled result word changed");

endmodule

bind i2c_bitbang_master_core i2cbb_chk u_i2cbb_chk (.*);

/* dv/tb_i2c_bitbang_master_core.sv */
// Self-checking testbench for the I2C bit-level master core: tick words in, bus words out.
`timescale 1ns / 1ps

module tb_i2c_bitbang_master_core;
    import i2cbb_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_PHASE_TICKS = '0;
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] txb;
        logic       sack;
        logic       sda;
    } t_tick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_op = '0;
    logic [7:0]  i_tx_byte = '0;
    logic        i_send_ack = 1'b0;
    logic        i_sda_in = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_scl_low;
    logic        o_sda_low;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_rx_byte;
    logic        o_ack_missing;
    logic        o_cmd_rejected;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_bitbang_master_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_tx_byte      (i_tx_byte),
        .i_send_ack     (i_send_ack),
        .i_sda_in       (i_sda_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_scl_low      (o_scl_low),
        .o_sda_low      (o_sda_low),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_rx_byte      (o_rx_byte),
        .o_ack_missing  (o_ack_missing),
        .o_cmd_rejected (o_cmd_rejected),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // Bus sequencer shadow: configuration, state and pins
    logic [7:0] ptk = PHASE_TICKS_RESET;
    t_state     bus_st = S_IDLE;
    logic [2:0] bit_no = '0;
    logic [7:0] hold_cnt = '0;
    logic [7:0] tx_sr = '0;
    logic [7:0] rx_sr = '0;
    logic [7:0] rx_held = '0;
    logic       ack_want = 1'b0;
    logic       nack_seen = 1'b0;
    logic       scl_dr = 1'b0;
    logic       sda_dr = 1'b0;

    t_tick   tick_q[$];
    t_result res_q[$];
    bit      offer_live = 1'b0;
    bit      send_idle_en = 1'b1;
    bit      recv_idle_en = 1'b1;
    bit      hold_req = 1'b0;
    int      hold_left = 0;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      words_queued = 0;
    int      words_taken = 0;
    int      results_seen = 0;
    int      err_cnt = 0;
    int      rejects = 0;
    int      cmd_seen [8];
    t_result want;
    t_result seen;

    function automatic void open_phase(t_state st, logic sda);
        bus_st = st;
        hold_cnt = (ptk == 8'd0) ? 8'd0 : ptk - 8'd1;
        case (st)
            S_ST_A:     begin scl_dr = 1'b0; sda_dr = 1'b1; end
            S_ST_B:     begin scl_dr = 1'b1; sda_dr = 1'b1; end
            S_SP_A:     begin scl_dr = 1'b0; sda_dr = 1'b1; end
            S_SP_B:     sda_dr = 1'b0;
            S_WR_DATA:  sda_dr = ~tx_sr[3'd7 - bit_no];
            S_WR_HI:    scl_dr = 1'b0;
            S_WR_LO:    scl_dr = 1'b1;
            S_WR_AKHI:  begin sda_dr = 1'b0; scl_dr = 1'b0; end
            S_WR_AKLO:  begin nack_seen = sda; scl_dr = 1'b1; end
            S_RD_HI:    begin scl_dr = 1'b0; sda_dr = 1'b0; end
            S_RD_LO: begin
                // sample the data bit as SCL goes low
                if (sda) rx_sr[3'd7 - bit_no] = 1'b1;
                scl_dr = 1'b1;
            end
            S_RD_AKSDA: sda_dr = 1'b1;
            S_RD_AKHI:  scl_dr = 1'b0;
            S_RD_AKLO:  scl_dr = 1'b1;
            S_RD_AKREL: sda_dr = 1'b0;
            default: ;
        endcase
    endfunction

    function automatic void next_phase(logic sda);
        case (bus_st)
            S_ST_A:    open_phase(S_ST_B, sda);
            S_SP_A:    open_phase(S_SP_B, sda);
            S_WR_DATA: open_phase(S_WR_HI, sda);
            S_WR_HI:   open_phase(S_WR_LO, sda);
            S_WR_LO: begin
                if (bit_no == 3'd7) begin
                    open_phase(S_WR_AKHI, sda);
                end else begin
                    bit_no = bit_no + 3'd1;
                    open_phase(S_WR_DATA, sda);
                end
            end
            S_WR_AKHI: open_phase(S_WR_AKLO, sda);
            S_RD_HI:   open_phase(S_RD_LO, sda);
            S_RD_LO: begin
                if (bit_no != 3'd7) begin
                    bit_no = bit_no + 3'd1;
                    open_phase(S_RD_HI, sda);
                end else if (ack_want) begin
                    open_phase(S_RD_AKSDA, sda);
                end else begin
                    open_phase(S_RD_AKHI, sda);
                end
            end
            S_RD_AKSDA: open_phase(S_RD_AKHI, sda);
            S_RD_AKHI:  open_phase(S_RD_AKLO, sda);
            S_RD_AKLO: begin
                if (ack_want) open_phase(S_RD_AKREL, sda);
            end
            default: ;
        endcase
    endfunction

    // Advance the sequencer shadow by one tick and return the bus word it yields
    function automatic t_result bus_tick(logic [2:0] op, logic [7:0] txb, logic sack,
                                         logic sda);
        t_result r;
        logic    fin;
        r = '0;
        fin = 1'b0;
        if (bus_st == S_IDLE) begin
            bit_no = '0;
            if (op >= OP_START && op <= OP_READ) cmd_seen[op]++;
            case (op)
                OP_START: open_phase(S_ST_A, sda);
                OP_STOP:  open_phase(S_SP_A, sda);
                OP_WRITE: begin tx_sr = txb; open_phase(S_WR_DATA, sda); end
                OP_READ: begin
                    rx_sr = '0;
                    ack_want = sack;
                    open_phase(S_RD_HI, sda);
                end
                default: ;
            endcase
        end else begin
            r.cmd_rejected = (op != OP_TICK);
            if (hold_cnt > 0) hold_cnt = hold_cnt - 8'd1;
            else next_phase(sda);
        end
        if (bus_st != S_IDLE && hold_cnt == 0 &&
            (bus_st == S_ST_B || bus_st == S_SP_B || bus_st == S_WR_AKLO ||
             bus_st == S_RD_AKREL || (bus_st == S_RD_AKLO && !ack_want))) begin
            if (bus_st == S_RD_AKLO || bus_st == S_RD_AKREL) rx_held = rx_sr;
            bus_st = S_IDLE;
            fin = 1'b1;
        end
        if (r.cmd_rejected) rejects++;
        r.scl_low = scl_dr;
        r.sda_low = sda_dr;
        r.busy_res = (bus_st != S_IDLE);
        r.done_res = fin;
        r.rx_byte = rx_held;
        r.ack_missing = nack_seen;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) $display("ERROR t=%0t result %0d: %s", $realtime,
                                            results_seen, msg);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
        if (got !== exp_v) note_mismatch($sformatf("%s got %0h want %0h", name, got, exp_v));
    endtask

    // Sender: present the oldest pending word, hold it until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (offer_live) begin
        end else if (send_gap > 0) begin
            send_gap--;
            i_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
            i_valid <= 1'b1;
            i_op <= tick_q[0].op;
            i_tx_byte <= tick_q[0].txb;
            i_send_ack <= tick_q[0].sack;
            i_sda_in <= tick_q[0].sda;
            offer_live = 1'b1;
            if (send_idle_en && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 18);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_stall <= 1'b1;
        end else if (recv_idle_en && $urandom_range(0, 11) == 0) begin
            recv_gap = $urandom_range(0, 17);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Predict on every accepted tick word, check every accepted bus word
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            res_q.push_back(bus_tick(i_op, i_tx_byte, i_send_ack, i_sda_in));
            tick_q.delete(0);
            offer_live = 1'b0;
            words_taken++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            seen = {o_scl_low, o_sda_low, o_busy_res, o_done_res, o_rx_byte,
                    o_ack_missing, o_cmd_rejected};
            if (res_q.size() == 0) begin
                note_mismatch("bus word with nothing expected");
            end else begin
                want = res_q.pop_front();
                cmp_field("scl_low", 8'(seen.scl_low), 8'(want.scl_low));
                cmp_field("sda_low", 8'(seen.sda_low), 8'(want.sda_low));
                cmp_field("busy_res", 8'(seen.busy_res), 8'(want.busy_res));
                cmp_field("done_res", 8'(seen.done_res), 8'(want.done_res));
                cmp_field("rx_byte", seen.rx_byte, want.rx_byte);
                cmp_field("ack_missing", 8'(seen.ack_missing), 8'(want.ack_missing));
                cmp_field("cmd_rejected", 8'(seen.cmd_rejected), 8'(want.cmd_rejected));
            end
        end
    end

    task automatic apb_write(input logic [7:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_PHASE_TICKS;
        pwdata <= {24'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        ptk = v;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_tick(input logic [2:0] op, input logic [7:0] txb, input logic sack,
                             input logic sda);
        t_tick w;
        w.op = op;
        w.txb = txb;
        w.sack = sack;
        w.sda = sda;
        tick_q.push_back(w);
        words_queued++;
    endtask

    function automatic logic pick_sda(int mode);
        if (mode == SDA_LOW) return 1'b0;
        if (mode == SDA_HIGH) return 1'b1;
        return 1'($urandom);
    endfunction

    // Ticks a command keeps the sequencer busy, the accepting tick included
    function automatic int cmd_len(logic [2:0] op, logic sack);
        int eff;
        eff = (ptk == 8'd0) ? 1 : int'(ptk);
        case (op)
            OP_START, OP_STOP: return 2 * eff;
            OP_WRITE:          return 26 * eff;
            OP_READ:           return (sack ? 20 : 18) * eff;
            default:           return 1;
        endcase
    endfunction

    // Queue a command and the ticks that carry it; cut > 0 lets the next one land early
    task automatic issue(input logic [2:0] op, input logic [7:0] txb, input logic sack,
                         input int sda_mode, input int noise_pct, input int cut);
        int         len;
        logic [2:0] fop;
        len = cmd_len(op, sack) - cut;
        push_tick(op, txb, sack, pick_sda(sda_mode));
        for (int k = 1; k < len; k++) begin
            fop = OP_TICK;
            if ($urandom_range(0, 99) < noise_pct) fop = 3'($urandom_range(1, 7));
            push_tick(fop, 8'($urandom), 1'($urandom), pick_sda(sda_mode));
        end
    endtask

    // Close any open command with plain ticks, then let every bus word drain
    task automatic settle();
        while (1) begin
            while (tick_q.size() != 0) @(negedge i_clk);
            if (bus_st == S_IDLE) break;
            push_tick(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
        end
        while (res_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_traffic(input int budget, input bit with_hold);
        int         stop_at;
        int         nb;
        int         seq_no;
        bit         rd;
        logic [2:0] op;
        logic       sack;
        stop_at = words_queued + budget;
        seq_no = 0;
        while (words_queued < stop_at) begin
            seq_no++;
            if ($urandom_range(0, 9) < 8) begin
                // well-formed transfer: start, address, data bytes, stop
                issue(OP_START, 8'($urandom), 1'($urandom), SDA_RAND, 0, 0);
                issue(OP_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, 0, 0);
                nb = $urandom_range(1, 3);
                rd = 1'($urandom);
                for (int k = 0; k < nb; k++) begin
                    if (rd) issue(OP_READ, 8'($urandom), k < nb - 1, SDA_RAND, 0, 0);
                    else issue(OP_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, 0, 0);
                end
                issue(OP_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 0, 0);
            end else begin
                // broken sequence: any op, maybe cut short, with stray ops while busy
                op = 3'($urandom_range(0, 7));
                sack = 1'($urandom);
                issue(op, 8'($urandom), sack, SDA_RAND, 20,
                      $urandom_range(0, cmd_len(op, sack) - 1));
            end
            repeat ($urandom_range(0, 3)) begin
                op = OP_TICK;
                if ($urandom_range(0, 3) == 0) op = 3'($urandom_range(OP_READ + 1, 7));
                push_tick(op, 8'($urandom), 1'($urandom), 1'($urandom));
            end
            if (with_hold && seq_no == 2) hold_req = 1'b1;
            // hold the sender until every bus word is back
            if (seq_no % 5 == 0) begin
                while (tick_q.size() != 0 || res_q.size() != 0) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        for (int k = 0; k < 8; k++) cmd_seen[k] = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass at the reset phase length
        push_tick(OP_TICK, 8'h00, 1'b0, 1'b0);
        for (int u = OP_READ + 1; u < 8; u++) push_tick(3'(u), 8'hFF, 1'b1, 1'b1);
        issue(OP_START, 8'h00, 1'b0, SDA_RAND, 0, 0);
        issue(OP_WRITE, 8'h00, 1'b0, SDA_HIGH, 0, 0);
        issue(OP_WRITE, 8'hFF, 1'b1, SDA_LOW, 0, 0);
        issue(OP_WRITE, 8'hA5, 1'b0, SDA_RAND, 100, 0);
        issue(OP_READ, 8'h00, 1'b1, SDA_HIGH, 0, 0);
        issue(OP_READ, 8'hFF, 1'b0, SDA_LOW, 0, 0);
        issue(OP_READ, 8'h5A, 1'b1, SDA_RAND, 0, 0);
        issue(OP_STOP, 8'h00, 1'b0, SDA_RAND, 0, 0);
        issue(OP_START, 8'h00, 1'b0, SDA_RAND, 0, 1);
        issue(OP_STOP, 8'h00, 1'b0, SDA_RAND, 0, 0);
        issue(OP_STOP, 8'h00, 1'b0, SDA_RAND, 0, 0);
        settle();

        apb_write(8'd1);
        run_traffic(100, 1'b1);
        settle();

        apb_write(8'd0);
        run_traffic(60, 1'b0);
        settle();

        apb_write(8'd3);
        run_traffic(60, 1'b0);
        settle();

        apb_write(8'd16);
        issue(OP_START, 8'h00, 1'b0, SDA_RAND, 1, 0);
        issue(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1, 0);
        settle();

        // last stretch: no idling on either side
        apb_write(8'd2);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        run_traffic(100, 1'b0);

        while (tick_q.size() != 0 || res_q.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("covered %0d tick words and %0d bus words at phase lengths 2, 1, 0, 3, 16",
                 words_taken, results_seen);
        $display("commands run: %0d start, %0d stop, %0d write, %0d read, %0d rejected",
                 cmd_seen[OP_START], cmd_seen[OP_STOP], cmd_seen[OP_WRITE],
                 cmd_seen[OP_READ], rejects);
        if (err_cnt == 0) begin
            $display("i2c_bitbang_master_core: match");
        end else begin
            $display("i2c_bitbang_master_core: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TIMEOUT with %0d words pending, %0d bus words expected",
                 tick_q.size(), res_q.size());
        $display("i2c_bitbang_master_core: mismatch");
        $finish;
    end

endmodule
